FILE: rtl/core/msp_request_deframer_assert.svh
// ----------------------------------------------------------------------------
// msp request deframer assertion macros
// Short forms for clocked assertions with an active-low asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef MSP_REQUEST_DEFRAMER_ASSERT_SVH
`define MSP_REQUEST_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define MSP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("msp deframer assertion failed");

// next-cycle implication
`define MSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("msp deframer assertion failed");

`endif

FILE: rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp request deframer package
// Shared widths, protocol characters, event codes and beat structs.
// ----------------------------------------------------------------------------
package msp_pkg;

	localparam int MAX_BODY  = 2;
	localparam int BodyW     = 8 * MAX_BODY;
	localparam int LenW      = $clog2(MAX_BODY + 1);
	localparam int BodyIdxW  = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
	localparam int PayloadW  = 8 + LenW + BodyW;
	localparam int TdataW    = ((PayloadW + 7) / 8) * 8;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_M      = 8'h4d;
	localparam logic [7:0] CH_LT     = 8'h3c;
	localparam logic [7:0] NIB_MASK  = 8'hf0;
	localparam logic [7:0] TLM_NIB   = 8'h20;

	typedef enum logic [1:0] {
		EV_VALID   = 2'd0,
		EV_BADSUM  = 2'd1,
		EV_HANDOFF = 2'd2
	} msp_event_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} msp_beat_t;

	typedef struct packed {
		logic             valid;
		msp_event_t       kind;
		logic [7:0]       cmd;
		logic [LenW-1:0]  len;
		logic [BodyW-1:0] body;
	} msp_result_t;

endpackage

FILE: rtl/core/msp_in_stage.sv
// ----------------------------------------------------------------------------
// msp input stage
// Registers one received byte beat in front of the parser.
// ----------------------------------------------------------------------------
module msp_in_stage import msp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // rx_byte
	input  logic       advance,
	output msp_beat_t  beat
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	// take a new beat when empty or when the held one moves on this cycle
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign beat.valid = valid_s1;
	assign beat.data  = byte_s1;

endmodule

FILE: rtl/core/msp_parser.sv
// ----------------------------------------------------------------------------
// msp frame parser
// Per-byte state machine for request frames and the telemetry header sniffer.
// ----------------------------------------------------------------------------
module msp_parser import msp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  msp_beat_t   beat,
	input  logic        advance,
	output msp_result_t res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_GOT_DOLLAR, PH_GOT_M, PH_SIZE, PH_CMD, PH_BODY, PH_CHECK,
		PH_SKIP, PH_TLM2, PH_TLM3, PH_TLM4, PH_HANDED
	} phase_t;

	phase_t     phase_q, phase_n;
	logic [7:0] size_q, size_n;
	logic [7:0] cmd_q, cmd_n;
	logic [7:0] idx_q, idx_n;
	logic [7:0] xor_q, xor_n;
	logic [7:0] body_q [MAX_BODY];

	logic             fire;
	logic [7:0]       b;
	logic             body_wr;
	logic [LenW-1:0]  len;
	logic [BodyW-1:0] packed_body;

	assign fire = beat.valid && advance;
	assign b    = beat.data;
	assign len  = size_q[LenW-1:0];

	// only bytes of the current frame are reported
	always_comb begin
		for (int i = 0; i < MAX_BODY; i++) begin
			packed_body[8*i +: 8] = (i < int'(len)) ? body_q[i] : 8'h00;
		end
	end

	always_comb begin
		phase_n   = phase_q;
		size_n    = size_q;
		cmd_n     = cmd_q;
		idx_n     = idx_q;
		xor_n     = xor_q;
		body_wr   = 1'b0;
		res.valid = 1'b0;
		res.kind  = EV_VALID;
		res.cmd   = 8'h00;
		res.len   = '0;
		res.body  = '0;
		case (phase_q)
			PH_IDLE: begin
				if (b == CH_LT) begin
					phase_n = PH_TLM2;
				end else if (b == CH_DOLLAR) begin
					phase_n = PH_GOT_DOLLAR;
				end else begin
					phase_n = PH_IDLE;
				end
			end
			PH_GOT_DOLLAR: phase_n = (b == CH_M) ? PH_GOT_M : PH_IDLE;
			PH_GOT_M:      phase_n = (b == CH_LT) ? PH_SIZE : PH_IDLE;
			PH_SIZE: begin
				size_n  = b;
				xor_n   = b;
				phase_n = PH_CMD;
			end
			PH_CMD: begin
				idx_n = 8'h00;
				cmd_n = b;
				xor_n = xor_q ^ b;
				if (size_q > 8'(MAX_BODY)) begin
					phase_n = PH_SKIP;
				end else if (size_q == 8'h00) begin
					phase_n = PH_CHECK;
				end else begin
					phase_n = PH_BODY;
				end
			end
			PH_BODY: begin
				body_wr = (idx_q < 8'(MAX_BODY));
				idx_n   = idx_q + 8'd1;
				xor_n   = xor_q ^ b;
				phase_n = (idx_n >= size_q) ? PH_CHECK : PH_BODY;
			end
			PH_CHECK: begin
				res.valid = 1'b1;
				res.kind  = ((xor_q ^ b) != 8'h00) ? EV_BADSUM : EV_VALID;
				res.cmd   = cmd_q;
				res.len   = len;
				res.body  = packed_body;
				phase_n   = PH_IDLE;
			end
			PH_SKIP: begin
				// oversized body: consume body and checksum with no result
				if (idx_q == size_q) begin
					phase_n = PH_IDLE;
				end else begin
					idx_n = idx_q + 8'd1;
				end
			end
			PH_TLM2: phase_n = ((b & NIB_MASK) == TLM_NIB) ? PH_TLM3 : PH_IDLE;
			PH_TLM3: phase_n = PH_TLM4;
			PH_TLM4: begin
				if ((b & NIB_MASK) == 8'h00) begin
					res.valid = 1'b1;
					res.kind  = EV_HANDOFF;
					phase_n   = PH_HANDED;
				end else begin
					phase_n = PH_IDLE;
				end
			end
			PH_HANDED: phase_n = PH_HANDED;
			default:   phase_n = PH_IDLE;
		endcase
		res.valid = res.valid && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			size_q  <= 8'h00;
			cmd_q   <= 8'h00;
			idx_q   <= 8'h00;
			xor_q   <= 8'h00;
		end else if (fire) begin
			phase_q <= phase_n;
			size_q  <= size_n;
			cmd_q   <= cmd_n;
			idx_q   <= idx_n;
			xor_q   <= xor_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && body_wr) begin
			body_q[idx_q[BodyIdxW-1:0]] <= b;
		end
	end

endmodule

FILE: rtl/core/msp_out_stage.sv
// ----------------------------------------------------------------------------
// msp output stage
// Result register that holds one event beat until the sink takes it.
// ----------------------------------------------------------------------------
module msp_out_stage import msp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  msp_result_t       res,
	output logic              advance,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [TdataW-1:0] m_tdata,
	output logic [1:0]        m_tuser
);

	logic              valid_q;
	logic [TdataW-1:0] data_q;
	logic [1:0]        kind_q;

	assign advance = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			data_q <= TdataW'({res.body, res.len, res.cmd});
			kind_q <= res.kind;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = kind_q;

endmodule

FILE: rtl/core/msp_request_deframer.sv
// results: the checksum or telemetry byte passes from the input register through the
// combinational parser into the result register; other bytes give no result beat
// throughput: one byte per cycle while no result beat stalls, set by the combinational
// per-byte parser between the input register and the result register
// stalls: while a result beat waits for m_tready no further byte is parsed
// reset: arst_n clears the parser to idle, leaves handoff and empties both stages
// ----------------------------------------------------------------------------
// msp request deframer
// Recognizes msp v1 request frames and a foreign telemetry header in a byte stream.
// ----------------------------------------------------------------------------
module msp_request_deframer import msp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [TdataW-1:0] m_tdata,   // command_id, body_length, body_bytes, zero pad
	output logic [1:0]        m_tuser    // event_kind
);

	msp_beat_t   beat;
	msp_result_t res;
	logic        advance;

	msp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.advance  (advance),
		.beat     (beat)
	);

	msp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat    (beat),
		.advance (advance),
		.res     (res)
	);

	msp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.advance  (advance),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: rtl/core/msp_checker.sv
// ----------------------------------------------------------------------------
// msp deframer port checker
// Watches the top-level ports for event encoding and handoff rules.
// ----------------------------------------------------------------------------
`include "msp_request_deframer_assert.svh"

module msp_checker import msp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic [7:0]        s_tdata,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [TdataW-1:0] m_tdata,
	input logic [1:0]        m_tuser
);

	logic stalled;
	logic handoff_taken;
	logic empty_body;
	logic in_seen;

	assign stalled       = m_tvalid && !m_tready;
	assign handoff_taken = m_tvalid && m_tready && (m_tuser == EV_HANDOFF);
	assign empty_body    = m_tvalid && (m_tdata[8 +: LenW] == '0);
	assign in_seen       = s_tvalid && s_tready && (s_tdata != 8'h00 || s_tdata == 8'h00);

	// a stalled result beat holds
	`MSP_ASSERT_NEXT(a_hold, clk, arst_n, stalled, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// handoff carries no command or body
	`MSP_ASSERT_IMPLY(a_handoff_zero, clk, arst_n, m_tvalid && m_tuser == EV_HANDOFF, m_tdata == '0)
	// no body bytes reported for an empty frame
	`MSP_ASSERT_IMPLY(a_empty_body, clk, arst_n, empty_body, m_tdata[8+LenW +: BodyW] == '0)
	// nothing follows the handoff until reset
	`MSP_ASSERT_NEXT(a_after_handoff, clk, arst_n, handoff_taken, !m_tvalid)
	// event kind stays within its three codes
	`MSP_ASSERT_IMPLY(a_kind, clk, arst_n, m_tvalid || in_seen, !m_tvalid || m_tuser != 2'd3)

endmodule

bind msp_request_deframer msp_checker u_msp_checker (.*);

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// msp request deframer testbench
// Drives byte streams of request frames, broken headers, oversized bodies and
// telemetry headers into the deframer, predicts every result beat with a
// byte-level parser of its own and compares each result beat field by field.
// ----------------------------------------------------------------------------
module testbench;
	import msp_pkg::*;

	typedef enum {
		ST_IDLE, ST_DOLLAR, ST_M, ST_SIZE, ST_CMD, ST_BODY, ST_CHECK, ST_SKIP,
		ST_TLM2, ST_TLM3, ST_TLM4, ST_HANDED
	} parse_st_t;

	typedef struct {
		msp_event_t       kind;
		logic [7:0]       cmd;
		logic [LenW-1:0]  len;
		logic [BodyW-1:0] body;
	} deframe_result_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [TdataW-1:0] m_tdata;
	logic [1:0]        m_tuser;

	// parser copy that tracks every accepted byte
	parse_st_t  st;
	logic [7:0] fsize;
	logic [7:0] fcmd;
	logic [7:0] fidx;
	logic [7:0] fxor;
	logic [7:0] fbody [MAX_BODY];

	deframe_result_t pending_results[$];
	deframe_result_t want;

	int error_count;
	int src_idle_pct;
	int sink_idle_pct;
	int sink_hold_req;
	int bytes_sent;
	int huge_left;
	bit handoff_armed;

	msp_request_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("*** FAILED ***");
		$finish;
	end

	function void track_byte(logic [7:0] b);
		deframe_result_t r;
		r.kind = EV_VALID;
		r.cmd  = '0;
		r.len  = '0;
		r.body = '0;
		case (st)
			ST_IDLE: begin
				if (b == CH_LT)
					st = ST_TLM2;
				else if (b == CH_DOLLAR)
					st = ST_DOLLAR;
			end
			ST_DOLLAR: st = (b == CH_M) ? ST_M : ST_IDLE;
			ST_M:      st = (b == CH_LT) ? ST_SIZE : ST_IDLE;
			ST_SIZE: begin
				fsize = b;
				fxor  = b;
				st    = ST_CMD;
			end
			ST_CMD: begin
				fidx = '0;
				fcmd = b;
				fxor ^= b;
				if (fsize > MAX_BODY)
					st = ST_SKIP;
				else
					st = (fsize == 0) ? ST_CHECK : ST_BODY;
			end
			ST_BODY: begin
				if (fidx < MAX_BODY)
					fbody[fidx] = b;
				fidx = fidx + 8'd1;
				fxor ^= b;
				if (fidx >= fsize)
					st = ST_CHECK;
			end
			ST_CHECK: begin
				r.kind = ((fxor ^ b) != 8'h00) ? EV_BADSUM : EV_VALID;
				r.cmd  = fcmd;
				r.len  = fsize[LenW-1:0];
				for (int i = 0; i < MAX_BODY; i++)
					if (i < fsize)
						r.body[8*i +: 8] = fbody[i];
				pending_results.push_back(r);
				st = ST_IDLE;
			end
			ST_SKIP: begin
				if (fidx == fsize)
					st = ST_IDLE;
				else
					fidx = fidx + 8'd1;
			end
			ST_TLM2: st = ((b & NIB_MASK) == TLM_NIB) ? ST_TLM3 : ST_IDLE;
			ST_TLM3: st = ST_TLM4;
			ST_TLM4: begin
				if ((b & NIB_MASK) == 8'h00) begin
					r.kind = EV_HANDOFF;
					pending_results.push_back(r);
					st = ST_HANDED;
				end else begin
					st = ST_IDLE;
				end
			end
			default: ;
		endcase
	endfunction

	// entered and left at a falling edge
	task automatic send_byte(input logic [7:0] b);
		// handoff is final until reset, so it is kept back for the last test
		if (!handoff_armed && st == ST_TLM4 && b[7:4] == 4'h0)
			b[4] = 1'b1;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do
			@(posedge clk);
		while (!s_tready);
		track_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [7:0] size, input logic [7:0] cmd, input bit bad);
		logic [7:0] sum;
		logic [7:0] d;
		send_byte(CH_DOLLAR);
		send_byte(CH_M);
		send_byte(CH_LT);
		send_byte(size);
		send_byte(cmd);
		sum = size ^ cmd;
		for (int i = 0; i < size; i++) begin
			d = 8'($urandom_range(255));
			send_byte(d);
			sum ^= d;
		end
		if (bad)
			sum ^= 8'($urandom_range(255, 1));
		send_byte(sum);
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idle(input int src_pct, input int sink_pct);
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
	endtask

	// result beat checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: event_kind %0d tdata %h", m_tuser, m_tdata);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.kind) begin
					$error("event_kind: expected %0d, got %0d", want.kind, m_tuser);
					error_count++;
				end
				if (m_tdata[7:0] !== want.cmd) begin
					$error("command_id: expected %h, got %h", want.cmd, m_tdata[7:0]);
					error_count++;
				end
				if (m_tdata[8 +: LenW] !== want.len) begin
					$error("body_length: expected %0d, got %0d", want.len, m_tdata[8 +: LenW]);
					error_count++;
				end
				if (m_tdata[8+LenW +: BodyW] !== want.body) begin
					$error("body_bytes: expected %h, got %h", want.body,
						m_tdata[8+LenW +: BodyW]);
					error_count++;
				end
				if (m_tdata[TdataW-1:PayloadW] !== '0) begin
					$error("tdata pad: expected 0, got %h", m_tdata[TdataW-1:PayloadW]);
					error_count++;
				end
			end
		end
	end

	// receiver: random stalls, or a long hold-off when a test asks for one
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_req > 0) begin
				hold_left     = sink_hold_req;
				sink_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	task automatic test_basic_frames();
		// empty body, smallest command
		send_frame(8'd0, 8'h00, 1'b0);
		// full body with extreme bytes, largest command, bad checksum
		send_byte(CH_DOLLAR);
		send_byte(CH_M);
		send_byte(CH_LT);
		send_byte(8'd2);
		send_byte(8'hff);
		send_byte(8'hff);
		send_byte(8'h00);
		send_byte(8'h01);
		send_frame(8'd1, 8'h80, 1'b0);
	endtask

	task automatic test_broken_headers();
		// second dollar is not taken as a new start
		send_byte(CH_DOLLAR);
		send_byte(CH_DOLLAR);
		send_byte(CH_M);
		// dollar m then something other than the request mark
		send_byte(CH_DOLLAR);
		send_byte(CH_M);
		send_byte(CH_M);
		// telemetry header broken on its second and on its fourth byte
		send_byte(CH_LT);
		send_byte(8'h1f);
		send_byte(CH_LT);
		send_byte(8'h2f);
		send_byte(8'hab);
		send_byte(8'hf0);
	endtask

	task automatic test_oversized_skip();
		send_frame(8'd3, 8'h12, 1'b0);
		send_frame(8'd2, 8'h34, 1'b0);
	endtask

	task automatic test_output_stall();
		set_idle(0, 0);
		sink_hold_req = 300;
		for (int i = 0; i < 30; i++)
			send_frame(8'($urandom_range(MAX_BODY)), 8'($urandom_range(255)),
				($urandom_range(3) == 0));
		wait_results_drained();
	endtask

	task automatic random_traffic(input int n_bytes);
		int stop_at;
		int r;
		logic [7:0] size;
		logic [7:0] b;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			r = $urandom_range(99);
			if (r < 70) begin
				r = $urandom_range(99);
				if (r < 70)
					size = 8'($urandom_range(MAX_BODY));
				else if (r < 92)
					size = 8'($urandom_range(8, MAX_BODY + 1));
				else if (r < 98 || huge_left == 0)
					size = 8'($urandom_range(40, 9));
				else begin
					size = 8'hff;
					huge_left--;
				end
				send_frame(size, 8'($urandom_range(255)), ($urandom_range(4) == 0));
			end else if (r < 80) begin
				repeat ($urandom_range(4, 1))
					send_byte(8'($urandom_range(255)));
			end else if (r < 87) begin
				b = 8'($urandom_range(255));
				send_byte(CH_DOLLAR);
				send_byte((b == CH_M) ? 8'h00 : b);
			end else if (r < 92) begin
				b = 8'($urandom_range(255));
				send_byte(CH_DOLLAR);
				send_byte(CH_M);
				send_byte((b == CH_LT) ? 8'hff : b);
			end else begin
				send_byte(CH_LT);
				if ($urandom_range(3) != 0)
					send_byte({4'h2, 4'($urandom_range(15))});
				else
					send_byte(8'($urandom_range(255)));
				send_byte(8'($urandom_range(255)));
				send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	task automatic test_random_traffic();
		set_idle(30, 67);
		random_traffic(80);
		set_idle(67, 30);
		random_traffic(80);
		set_idle(0, 0);
		random_traffic(80);
		wait_results_drained();
	endtask

	// must run last: only reset leaves the handed-off state
	task automatic test_handoff();
		set_idle(30, 30);
		// finish whatever frame or header the random traffic left open
		while (st != ST_IDLE)
			send_byte(8'h00);
		handoff_armed = 1'b1;
		send_byte(CH_LT);
		send_byte({4'h2, 4'($urandom_range(15))});
		send_byte(8'($urandom_range(255)));
		send_byte({4'h0, 4'($urandom_range(15))});
		// everything after the handoff is dropped
		for (int i = 0; i < 4; i++)
			send_frame(8'($urandom_range(MAX_BODY)), 8'($urandom_range(255)), 1'b0);
		repeat (20)
			send_byte(8'($urandom_range(255)));
		wait_results_drained();
	endtask

	initial begin
		error_count   = 0;
		bytes_sent    = 0;
		huge_left     = 2;
		sink_hold_req = 0;
		handoff_armed = 1'b0;
		st            = ST_IDLE;
		fsize         = '0;
		fcmd          = '0;
		fidx          = '0;
		fxor          = '0;
		for (int i = 0; i < MAX_BODY; i++)
			fbody[i] = '0;
		set_idle(30, 67);
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_basic_frames();
		test_broken_headers();
		test_oversized_skip();
		wait_results_drained();
		test_output_stall();
		test_random_traffic();
		test_handoff();

		repeat (10) @(negedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
